>>> hw/rtl/bil_pkg.sv
// Shared types and codes for the bounded insertion list.
// No dependencies; used by bil_cell and bounded_insertion_list_core.
`timescale 1ns / 1ps

package bil_pkg;

    // Command codes carried on s_command
    localparam logic [2:0] CMD_FRONT     = 3'd0;
    localparam logic [2:0] CMD_APPEND    = 3'd1;
    localparam logic [2:0] CMD_INSERT_AT = 3'd2;
    localparam logic [2:0] CMD_READ_AT   = 3'd3;
    localparam logic [2:0] CMD_CLEAR     = 3'd4;

    // Fixed payload widths of the ports
    localparam int unsigned CMD_BITS   = 3;
    localparam int unsigned POS_BITS   = 4;
    localparam int unsigned VALUE_BITS = 32;
    localparam int unsigned COUNT_BITS = 5;

    // Per-cell control: load the new word, or take the lower neighbour's word
    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

endpackage

>>> hw/rtl/bounded_insertion_list_core.sv
// Bounded insertion list: top level with command decode, cell row and result register.
// Depends on bil_pkg and bil_cell.
`timescale 1ns / 1ps

// Result: registered, and valid in the cycle after its request is accepted.
// Throughput: one request per cycle while m_ready stays high; every command finishes in the cycle it is
//   accepted because all cells shift together, so only the result register paces it.
// Reset (aresetn low, synchronous): count and result valid clear; entry words are
//   not reset and hold no meaning until written.

module bounded_insertion_list_core #(
    parameter int unsigned CAPACITY  = 16,
    parameter int unsigned WORD_BITS = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // request channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [bil_pkg::CMD_BITS-1:0]      s_command,
    input  logic [bil_pkg::POS_BITS-1:0]      s_position,
    input  logic [bil_pkg::VALUE_BITS-1:0]    s_entry_value,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_ok,
    output logic [bil_pkg::VALUE_BITS-1:0]    m_read_value,
    output logic [bil_pkg::COUNT_BITS-1:0]    m_entry_count
);

    // Count holds 0..CAPACITY; slot index holds 0..CAPACITY-1
    localparam int unsigned CNT_W   = $clog2(CAPACITY + 1);
    localparam int unsigned IDX_W   = $clog2(CAPACITY);
    // Position compares happen at a width that holds both the port and the count
    localparam int unsigned CMP_W   = (CNT_W > bil_pkg::POS_BITS) ? CNT_W : bil_pkg::POS_BITS;
    // Only the first slots are reachable by a position on the port
    localparam int unsigned RD_SPAN = (CAPACITY < (1 << bil_pkg::POS_BITS)) ?
                                      CAPACITY : (1 << bil_pkg::POS_BITS);

    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;

    logic                 m_valid_reg;
    logic                 m_ok_reg;
    logic                 ok_next;
    logic [bil_pkg::VALUE_BITS-1:0] m_read_value_reg;
    logic [bil_pkg::VALUE_BITS-1:0] rd_next;
    logic [bil_pkg::COUNT_BITS-1:0] m_entry_count_reg;

    logic                 accept;
    logic                 room;
    logic                 pos_ok;
    logic                 ins_en;
    logic [CNT_W-1:0]     at_idx;
    logic [CMP_W-1:0]     pos_ext;
    logic [IDX_W-1:0]     rd_idx;
    logic [WORD_BITS-1:0] rd_word;
    logic [63:0]          rd_wide;
    logic [63:0]          in_wide;
    logic [WORD_BITS-1:0] ins_word;
    logic [15:0]          cnt_wide;

    logic [WORD_BITS-1:0]  word_q [CAPACITY];
    bil_pkg::cell_ctrl_t   cell_ctrl [CAPACITY];

    // Hand over a request whenever the result register is free or draining
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign pos_ext  = CMP_W'(s_position);
    assign rd_idx   = pos_ext[IDX_W-1:0];
    assign in_wide  = 64'(s_entry_value);
    assign ins_word = in_wide[WORD_BITS-1:0];

    assign room   = cnt_reg < CNT_W'(CAPACITY);
    assign pos_ok = pos_ext < CMP_W'(cnt_reg);

    // Read mux over the reachable slots only
    always_comb begin
        rd_word = '0;
        for (int j = 0; j < RD_SPAN; j++) begin
            if (rd_idx == IDX_W'(j)) begin
                rd_word = word_q[j];
            end
        end
    end
    assign rd_wide = 64'(rd_word);

    // Decode the command; a rejected one leaves the count and the cells alone
    always_comb begin
        ok_next  = 1'b0;
        rd_next  = '0;
        ins_en   = 1'b0;
        at_idx   = '0;
        cnt_next = cnt_reg;
        unique case (s_command)
            bil_pkg::CMD_FRONT: begin
                if (room) begin
                    ins_en  = 1'b1;
                    ok_next = 1'b1;
                end
            end
            bil_pkg::CMD_APPEND: begin
                if (room) begin
                    ins_en  = 1'b1;
                    at_idx  = cnt_reg;
                    ok_next = 1'b1;
                end
            end
            bil_pkg::CMD_INSERT_AT: begin
                if (room && pos_ok) begin
                    ins_en  = 1'b1;
                    at_idx  = pos_ext[CNT_W-1:0];
                    ok_next = 1'b1;
                end
            end
            bil_pkg::CMD_READ_AT: begin
                if (pos_ok) begin
                    rd_next = rd_wide[bil_pkg::VALUE_BITS-1:0];
                    ok_next = 1'b1;
                end
            end
            bil_pkg::CMD_CLEAR: begin
                cnt_next = '0;
                ok_next  = 1'b1;
            end
            default: begin
                // unused codes: reject, keep state
            end
        endcase
        if (ins_en) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    assign cnt_wide = 16'(cnt_next);

    // Row of cells: the insert slot loads, every slot above it takes its neighbour
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [WORD_BITS-1:0] prev_word;

        assign cell_ctrl[i].load  = accept && ins_en && (at_idx == CNT_W'(i));
        assign cell_ctrl[i].shift = accept && ins_en && (at_idx < CNT_W'(i));

        if (i == 0) begin : g_first
            assign prev_word = ins_word;
        end else begin : g_rest
            assign prev_word = word_q[i-1];
        end

        bil_cell #(
            .WORD_BITS (WORD_BITS)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (cell_ctrl[i]),
            .new_word  (ins_word),
            .prev_word (prev_word),
            .word_q    (word_q[i])
        );
    end

    // Count and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                cnt_reg     <= cnt_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: load on accept, hold otherwise
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_ok_reg          <= ok_next;
            m_read_value_reg  <= rd_next;
            m_entry_count_reg <= cnt_wide[bil_pkg::COUNT_BITS-1:0];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_ok          = m_ok_reg;
    assign m_read_value  = m_read_value_reg;
    assign m_entry_count = m_entry_count_reg;

    function automatic logic [bil_pkg::COUNT_BITS-1:0] COUNT_BITS_OF(input logic [CNT_W-1:0] c);
        logic [15:0] w;
        w = 16'(c);
        return w[bil_pkg::COUNT_BITS-1:0];
    endfunction

    // Count never runs past the number of cells
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    // A successful insert grows the list by exactly one
    a_ins_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && ins_en) |=> (cnt_reg == $past(cnt_reg) + CNT_W'(1)))
        else $error("insert did not grow the list by one");

    // A rejected or non-read result carries a zero word
    a_rd_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !(ok_next && s_command == bil_pkg::CMD_READ_AT)) |=> (m_read_value == '0))
        else $error("non-zero read value on a result that is not a read");

    // Reported count follows the list count
    a_cnt_report: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (m_entry_count == COUNT_BITS_OF(cnt_reg)))
        else $error("reported count differs from list count");

endmodule

>>> hw/rtl/bil_cell.sv
// One storage cell of the list: holds a single entry word.
// Depends on bil_pkg (cell_ctrl_t).
`timescale 1ns / 1ps

module bil_cell #(
    parameter int unsigned WORD_BITS = 32
) (
    input  logic                  aclk,
    input  bil_pkg::cell_ctrl_t   ctrl,
    input  logic [WORD_BITS-1:0]  new_word,
    input  logic [WORD_BITS-1:0]  prev_word,
    output logic [WORD_BITS-1:0]  word_q
);

    logic [WORD_BITS-1:0] word_reg;
    logic [WORD_BITS-1:0] word_next;

    // Load wins over shift; otherwise hold
    always_comb begin
        word_next = word_reg;
        if (ctrl.load) begin
            word_next = new_word;
        end else if (ctrl.shift) begin
            word_next = prev_word;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign word_q = word_reg;

endmodule
